// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/macm_pkg.sv =====
// Types and constants of the memory access coverage map.
`default_nettype none

package macm_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned BUS_AW        = 16;
  localparam int unsigned CNT_W         = 17;
  localparam int unsigned FLAG_W        = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned FLAG_CODE_BIT  = 0;
  localparam int unsigned FLAG_INSTR_BIT = 1;
  localparam int unsigned FLAG_READ_BIT  = 2;
  localparam int unsigned FLAG_WR_BIT    = 3;

  typedef enum logic {
    OP_MARK,
    OP_QUERY
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_WALK
  } back_state_e;

  typedef struct packed {
    logic              func;
    logic              mem_request;
    logic              read_strobe;
    logic              write_strobe;
    logic              opcode_fetch;
    logic              starts_instruction;
    logic [BUS_AW-1:0] bus_address;
    logic [CNT_W-1:0]  range_start;
    logic [CNT_W-1:0]  range_end;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] untouched_count;
    logic [CNT_W-1:0] instruction_count;
    logic [CNT_W-1:0] code_count;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] written_count;
  } out_t;

  typedef struct packed {
    op_kind_e          kind;
    logic [FLAG_W-1:0] set;
    logic [BUS_AW-1:0] addr;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  fin;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== sv/macm_front.sv =====
// Front end: input handshake and classification of beats into map operations.
`default_nettype none

module macm_front (
  input  wire  macm_pkg::in_t        in_data_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  macm_pkg::q_stat_t    q_stat_i,
  input  wire  macm_pkg::back_stat_t back_stat_i,
  output logic                       push_o,
  output macm_pkg::op_t              op_o
);

  logic [macm_pkg::FLAG_W-1:0] set;

  always_comb begin
    set = '0;
    if (in_data_i.mem_request) begin
      if (in_data_i.read_strobe) begin
        if (in_data_i.opcode_fetch) begin
          set[macm_pkg::FLAG_CODE_BIT]  = 1'b1;
          set[macm_pkg::FLAG_INSTR_BIT] = in_data_i.starts_instruction;
        end else begin
          set[macm_pkg::FLAG_READ_BIT] = 1'b1;
        end
      end else if (in_data_i.write_strobe) begin
        set[macm_pkg::FLAG_WR_BIT] = 1'b1;
      end
    end
  end

  always_comb begin
    op_o.kind  = in_data_i.func ? macm_pkg::OP_QUERY : macm_pkg::OP_MARK;
    op_o.set   = set;
    op_o.addr  = in_data_i.bus_address;
    op_o.start = in_data_i.range_start;
    op_o.fin   = in_data_i.range_end;
  end

  assign in_ready_o = !q_stat_i.full && !back_stat_i.clearing;
  // drop bus cycles that mark nothing
  assign push_o     = in_valid_i && in_ready_o && (in_data_i.func || (|set));

endmodule

`default_nettype wire

// ===== sv/macm_fifo.sv =====
// Short operation queue between front end and back end.
`default_nettype none

module macm_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  wire  macm_pkg::op_t     op_i,
  input  wire                     pop_i,
  output macm_pkg::op_t           op_o,
  output macm_pkg::q_stat_t       stat_o
);

  localparam int unsigned Depth = macm_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);

  macm_pkg::op_t  mem_q [Depth];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  assign op_o         = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== sv/macm_back.sv =====
// Back end: flag memory, read-modify-write of marks and range walk of queries.
`default_nettype none

module macm_back #(
  parameter int unsigned ADDR_BITS = macm_pkg::ADDR_BITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  macm_pkg::op_t        op_i,
  input  wire                        op_valid_i,
  output logic                       op_pop_o,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output macm_pkg::out_t             out_data_o,
  output macm_pkg::back_stat_t       stat_o
);

  localparam int unsigned WW     = (ADDR_BITS + 1 > macm_pkg::CNT_W) ?
                                   ADDR_BITS + 1 : macm_pkg::CNT_W;
  localparam int unsigned MapSz  = 1 << ADDR_BITS;
  localparam logic [WW-1:0] MAP_END = WW'(MapSz);
  localparam int unsigned FW     = macm_pkg::FLAG_W;
  localparam int unsigned CW     = macm_pkg::CNT_W;

  macm_pkg::back_state_e state_q, state_d;

  logic [FW-1:0]        mem [MapSz];
  logic [FW-1:0]        rd_data_q;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [FW-1:0]        wdata;

  logic [ADDR_BITS-1:0] clr_q, clr_d;
  logic [WW-1:0]        cur_q, cur_d;
  logic [WW-1:0]        end_q, end_d;
  logic                 pend_q, pend_d;
  logic [FW-1:0]        set_q, set_d;
  logic [ADDR_BITS-1:0] maddr_q, maddr_d;
  macm_pkg::out_t       acc_q, acc_d;
  macm_pkg::out_t       out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  logic                 issue, finish;
  logic                 clr_last;
  logic [ADDR_BITS-1:0] op_addr;
  logic [WW-1:0]        op_end;

  assign clr_last = (clr_q == {ADDR_BITS{1'b1}});
  assign op_addr  = ADDR_BITS'(op_i.addr);
  assign op_end   = (WW'(op_i.fin) > MAP_END) ? MAP_END : WW'(op_i.fin);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      macm_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = macm_pkg::ST_IDLE;
        end
      end
      macm_pkg::ST_IDLE: begin
        if (op_valid_i) begin
          if (op_i.kind == macm_pkg::OP_MARK) begin
            state_d = macm_pkg::ST_MARK;
          end else if (!out_vld_q) begin
            state_d = macm_pkg::ST_WALK;
          end
        end
      end
      macm_pkg::ST_MARK: begin
        state_d = macm_pkg::ST_IDLE;
      end
      macm_pkg::ST_WALK: begin
        if ((cur_q >= end_q) && !pend_q) begin
          state_d = macm_pkg::ST_IDLE;
        end
      end
      default: state_d = macm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    op_pop_o = 1'b0;
    we       = 1'b0;
    waddr    = maddr_q;
    wdata    = rd_data_q | set_q;
    raddr    = op_addr;
    issue    = 1'b0;
    finish   = 1'b0;
    unique case (state_q)
      macm_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      macm_pkg::ST_IDLE: begin
        op_pop_o = op_valid_i && ((op_i.kind == macm_pkg::OP_MARK) || !out_vld_q);
      end
      macm_pkg::ST_MARK: begin
        we = 1'b1;
      end
      macm_pkg::ST_WALK: begin
        raddr  = cur_q[ADDR_BITS-1:0];
        issue  = (cur_q < end_q);
        finish = !issue && !pend_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    cur_d     = cur_q;
    end_d     = end_q;
    pend_d    = 1'b0;
    set_d     = set_q;
    maddr_d   = maddr_q;
    acc_d     = acc_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (state_q == macm_pkg::ST_CLEAR) begin
      clr_d = clr_q + ADDR_BITS'(1);
    end
    if (op_pop_o) begin
      maddr_d = op_addr;
      set_d   = op_i.set;
      cur_d   = WW'(op_i.start);
      end_d   = op_end;
      acc_d   = '0;
    end
    if (issue) begin
      cur_d  = cur_q + WW'(1);
      pend_d = 1'b1;
    end
    if (pend_q) begin
      if (rd_data_q == '0) begin
        acc_d.untouched_count = acc_q.untouched_count + CW'(1);
      end else begin
        acc_d.code_count = acc_q.code_count +
                           CW'(rd_data_q[macm_pkg::FLAG_CODE_BIT]);
        acc_d.instruction_count = acc_q.instruction_count +
                                  CW'(rd_data_q[macm_pkg::FLAG_INSTR_BIT]);
        acc_d.read_count = acc_q.read_count +
                           CW'(rd_data_q[macm_pkg::FLAG_READ_BIT]);
        acc_d.written_count = acc_q.written_count +
                              CW'(rd_data_q[macm_pkg::FLAG_WR_BIT]);
      end
    end
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (finish) begin
      out_d     = acc_q;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= macm_pkg::ST_CLEAR;
      clr_q     <= '0;
      cur_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cur_q     <= cur_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    set_q   <= set_d;
    maddr_q <= maddr_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[raddr];
  end

  assign out_valid_o     = out_vld_q;
  assign out_data_o      = out_q;
  assign stat_o.clearing = (state_q == macm_pkg::ST_CLEAR);

endmodule

`default_nettype wire

// ===== sv/memory_access_coverage_map.sv =====
// Bus cycle: the back end reads the flag entry when idle and writes it in the mark state;
//   the next beat is not taken from the queue until that read-modify-write is done.
// Query over N addresses: reads one flag entry per cycle, then registers the summed counts.
// Beats that mark nothing are dropped in the front end and never enter the queue.
// After reset the flag memory is swept to zero, all 2^ADDR_BITS entries (65536 by default);
//   no input beat is taken during the sweep.
`default_nettype none
`include "assert_macros.svh"

module memory_access_coverage_map #(
  parameter int unsigned ADDR_BITS = macm_pkg::ADDR_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  macm_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output macm_pkg::out_t        out_data_o
);

  macm_pkg::q_stat_t    q_stat;
  macm_pkg::back_stat_t back_stat;
  macm_pkg::op_t        front_op;
  macm_pkg::op_t        head_op;
  logic                 push;
  logic                 pop;

  macm_front u_front (
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_stat_i    (q_stat),
    .back_stat_i (back_stat),
    .push_o      (push),
    .op_o        (front_op)
  );

  macm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (q_stat)
  );

  macm_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (head_op),
    .op_valid_i  (!q_stat.empty),
    .op_pop_o    (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (back_stat)
  );

  `ASSERT_IMPLY(a_no_accept_in_sweep, clk_i, rst_ni, back_stat.clearing, !in_ready_o)
  `ASSERT_NEVER(a_queue_full_empty, clk_i, rst_ni, q_stat.full && q_stat.empty)
  `ASSERT_IMPLY(a_no_result_in_sweep, clk_i, rst_ni, back_stat.clearing, !out_valid_o)
  `ASSERT_NEXT(a_full_blocks_input, clk_i, rst_ni, q_stat.full && !pop, !in_ready_o)

endmodule

`default_nettype wire
